/* hw/rtl/trajectory_stop_detector_core_macros.svh */
// Assertion helpers for the stop detector core.
`ifndef TRAJECTORY_STOP_DETECTOR_CORE_MACROS_SVH
`define TRAJECTORY_STOP_DETECTOR_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TSD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stop detector check failed");

// Consequent must hold in the cycle after the antecedent.
`define TSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stop detector check failed");

`endif

/* hw/rtl/tsd_pkg.sv */
`timescale 1ns / 1ps

package tsd_pkg;

   localparam int MAX_POINTS  = 1024;
   localparam int IDX_W       = 10;
   localparam int CNT_W       = 11;
   localparam int TIME_W      = 40;
   localparam int COORD_W     = 32;
   localparam int MST_W       = 32;
   localparam int RAD_W       = 31;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 32;
   // scratch holds signed coordinates or unsigned distances
   localparam int SCR_W       = 36;
   localparam int ABS_W       = 34;
   localparam int SQ_W        = 2 * ABS_W + 1;
   localparam int ROOT_W      = 35;
   localparam int SRC_W       = 2 * ROOT_W;
   localparam int REM_W       = ROOT_W + 3;
   localparam int CYC_W       = 6;
   localparam int Q_W         = 40;
   // rank arithmetic: t = 9*(n-1), split by ten with a reciprocal
   localparam int RANK_T_W    = 14;
   localparam int RECIP       = 6554;
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 16;

   localparam logic [MST_W-1:0] MST_RESET = MST_W'(300000);
   localparam logic [RAD_W-1:0] RAD_RESET = RAD_W'(12800);

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_STOP_TIME = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_RADIUS   = CSR_IDX_W'(1);

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_READ = 1'b1
   } req_op_type;

   typedef enum logic [1:0] {
      PASS_X,
      PASS_Y,
      PASS_D
   } pass_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_OUT_RD,
      S_OUT_CHK,
      S_WIN_RD,
      S_WIN_CHK,
      S_WIN_END,
      S_G_RD,
      S_G_CHK,
      S_MUL,
      S_SQRT,
      S_G_END,
      S_RANK,
      S_RANK2,
      S_SEL_RD,
      S_SEL_CAND,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_SCAN_END,
      S_SEL_END,
      S_CMP,
      S_MARK
   } ctl_state_type;

   typedef enum logic [4:0] {
      DP_NONE,
      DP_OUT_RD,
      DP_OUT_CHK,
      DP_WIN_RD,
      DP_WIN_CHK,
      DP_WIN_END,
      DP_G_RD,
      DP_G_CHK,
      DP_MUL,
      DP_SQRT,
      DP_G_END,
      DP_RANK,
      DP_RANK2,
      DP_SEL_RD,
      DP_SEL_CAND,
      DP_SCAN_RD,
      DP_SCAN_CHK,
      DP_SCAN_END,
      DP_SEL_END,
      DP_CMP,
      DP_MARK
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      pass_type  pass;
   } dp_cmd_type;

   typedef struct packed {
      logic i_done;
      logic t_valid;
      logic win_more;
      logic win_ok;
      logic win_multi;
      logic g_done;
      logic g_both;
      logic mul_done;
      logic sqrt_last;
      logic nv_zero;
      logic sel_done;
      logic scan_done;
      logic radius_ok;
      logic mark_last;
   } dp_stat_type;

endpackage

/* hw/rtl/tsd_ctrl.sv */
`timescale 1ns / 1ps

module tsd_ctrl
   import tsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        eval_go,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd,
   output logic        busy
);

   ctl_state_type state_ff, state_in;
   pass_type      pass_ff, pass_in;

   // next state
   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      case (state_ff)
         S_IDLE:     if (eval_go) state_in = S_OUT_RD;
         S_OUT_RD:   state_in = stat.i_done ? S_IDLE : S_OUT_CHK;
         S_OUT_CHK:  state_in = stat.t_valid ? S_WIN_RD : S_OUT_RD;
         S_WIN_RD:   state_in = stat.win_more ? S_WIN_CHK : S_WIN_END;
         S_WIN_CHK:  state_in = stat.win_ok ? S_WIN_RD : S_WIN_END;
         S_WIN_END: begin
            pass_in  = PASS_X;
            state_in = stat.win_multi ? S_G_RD : S_OUT_RD;
         end
         S_G_RD:     state_in = stat.g_done ? S_G_END : S_G_CHK;
         S_G_CHK:    state_in = (pass_ff == PASS_D && stat.g_both) ? S_MUL : S_G_RD;
         S_MUL:      state_in = stat.mul_done ? S_SQRT : S_MUL;
         S_SQRT:     state_in = stat.sqrt_last ? S_G_RD : S_SQRT;
         S_G_END: begin
            if (stat.nv_zero) begin
               state_in = S_OUT_RD;
            end else if (pass_ff == PASS_D) begin
               state_in = S_RANK;
            end else begin
               state_in = S_SEL_RD;
            end
         end
         S_RANK:     state_in = S_RANK2;
         S_RANK2:    state_in = S_SEL_RD;
         S_SEL_RD:   state_in = stat.sel_done ? S_SEL_END : S_SEL_CAND;
         S_SEL_CAND: state_in = S_SCAN_RD;
         S_SCAN_RD:  state_in = stat.scan_done ? S_SCAN_END : S_SCAN_CHK;
         S_SCAN_CHK: state_in = S_SCAN_RD;
         S_SCAN_END: state_in = S_SEL_RD;
         S_SEL_END: begin
            case (pass_ff)
               PASS_X: begin
                  pass_in  = PASS_Y;
                  state_in = S_G_RD;
               end
               PASS_Y: begin
                  pass_in  = PASS_D;
                  state_in = S_G_RD;
               end
               default: state_in = S_CMP;
            endcase
         end
         S_CMP:      state_in = stat.radius_ok ? S_MARK : S_OUT_RD;
         S_MARK:     state_in = stat.mark_last ? S_OUT_RD : S_MARK;
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath command for each state
   always_comb begin
      cmd.pass = pass_ff;
      case (state_ff)
         S_OUT_RD:   cmd.op = DP_OUT_RD;
         S_OUT_CHK:  cmd.op = DP_OUT_CHK;
         S_WIN_RD:   cmd.op = DP_WIN_RD;
         S_WIN_CHK:  cmd.op = DP_WIN_CHK;
         S_WIN_END:  cmd.op = DP_WIN_END;
         S_G_RD:     cmd.op = DP_G_RD;
         S_G_CHK:    cmd.op = DP_G_CHK;
         S_MUL:      cmd.op = DP_MUL;
         S_SQRT:     cmd.op = DP_SQRT;
         S_G_END:    cmd.op = DP_G_END;
         S_RANK:     cmd.op = DP_RANK;
         S_RANK2:    cmd.op = DP_RANK2;
         S_SEL_RD:   cmd.op = DP_SEL_RD;
         S_SEL_CAND: cmd.op = DP_SEL_CAND;
         S_SCAN_RD:  cmd.op = DP_SCAN_RD;
         S_SCAN_CHK: cmd.op = DP_SCAN_CHK;
         S_SCAN_END: cmd.op = DP_SCAN_END;
         S_SEL_END:  cmd.op = DP_SEL_END;
         S_CMP:      cmd.op = DP_CMP;
         S_MARK:     cmd.op = DP_MARK;
         default:    cmd.op = DP_NONE;
      endcase
      busy = (state_ff != S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pass_ff  <= PASS_X;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
      end
   end

endmodule

/* hw/rtl/tsd_datapath.sv */
`timescale 1ns / 1ps

module tsd_datapath
   import tsd_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  dp_cmd_type                   cmd,
   output dp_stat_type                  stat,
   input  logic                         load_go,
   input  logic                         read_go,
   input  logic [TIME_W-1:0]            req_time_ms,
   input  logic                         req_time_valid,
   input  logic signed [COORD_W-1:0]    req_coord_x,
   input  logic                         req_x_valid,
   input  logic signed [COORD_W-1:0]    req_coord_y,
   input  logic                         req_y_valid,
   input  logic                         req_final_point,
   input  logic [IDX_W-1:0]             req_read_index,
   input  logic                         csr_write,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata,
   output logic                         rsp_valid,
   output logic [IDX_W-1:0]             rsp_point_index,
   output logic                         rsp_stop_flag,
   output logic [CNT_W-1:0]             rsp_point_count,
   output logic                         rsp_overflow
);

   // storage
   logic [TIME_W:0]         time_mem [MAX_POINTS];
   logic [COORD_W:0]        x_mem    [MAX_POINTS];
   logic [COORD_W:0]        y_mem    [MAX_POINTS];
   logic                    flag_mem [MAX_POINTS];
   logic signed [SCR_W-1:0] scr_mem  [MAX_POINTS];

   logic [TIME_W:0]         t_rd_ff;
   logic [COORD_W:0]        x_rd_ff, y_rd_ff;
   logic                    flag_rd_ff;
   logic signed [SCR_W-1:0] scr_rd_ff;

   // memory ports
   logic                    tm_we, xy_we, fl_we, scr_we, fl_wdata;
   logic [IDX_W-1:0]        tm_waddr, fl_waddr, scr_waddr, tm_raddr, xy_raddr, scr_raddr;
   logic signed [SCR_W-1:0] scr_wdata;

   // registers
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    ovf_ff, ovf_in, closed_ff, closed_in;
   logic [MST_W-1:0]        mst_ff, mst_in;
   logic [RAD_W-1:0]        rad_ff, rad_in;
   logic [CNT_W-1:0]        i_ff, i_in, k_ff, k_in, nv_ff, nv_in;
   logic [CNT_W-1:0]        j_ff, j_in, k2_ff, k2_in, lt_ff, lt_in, le_ff, le_in;
   logic [IDX_W-1:0]        we_ff, we_in, r0_ff, r0_in, r1_ff, r1_in;
   logic [TIME_W:0]         tend_ff, tend_in;
   logic signed [SCR_W-1:0] cand_ff, cand_in, v0_ff, v0_in, v1_ff, v1_in;
   logic signed [ABS_W-1:0] cx2_ff, cx2_in, cy2_ff, cy2_in;
   logic [ABS_W-1:0]        ay_ff, ay_in, mplier_ff, mplier_in;
   logic [SQ_W-2:0]         mcand_ff, mcand_in;
   logic [SQ_W-1:0]         acc_ff, acc_in;
   logic [CYC_W-1:0]        mcount_ff, mcount_in, scount_ff, scount_in;
   logic                    half_ff, half_in;
   logic [SRC_W-1:0]        src_ff, src_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [ROOT_W-1:0]       root_ff, root_in;
   logic [RANK_T_W-1:0]     t_ff, t_in;
   logic [IDX_W-1:0]        q_ff, q_in;
   logic [3:0]              m_ff, m_in;
   logic [Q_W-1:0]          q10_ff, q10_in;
   logic                    rsp_valid_ff, rsp_valid_in, rsp_hit_ff, rsp_hit_in;
   logic [IDX_W-1:0]        rsp_idx_ff, rsp_idx_in;
   logic [CNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic                    rsp_ovf_ff, rsp_ovf_in;

   // shared arithmetic
   logic signed [ABS_W:0]   dx_s, dy_s, ndx_s, ndy_s;
   logic [ABS_W-1:0]        ax, ay;
   logic [SQ_W-1:0]         acc_sum;
   logic [REM_W-1:0]        rem_sh, trial;
   logic                    sq_ge;
   logic [ROOT_W-1:0]       root_next;
   logic [Q_W-1:0]          lim;
   logic [CNT_W:0]          we_next;

   // offsets from the doubled centre and their magnitudes
   always_comb begin
      dx_s  = $signed({{2{x_rd_ff[COORD_W-1]}}, x_rd_ff[COORD_W-1:0], 1'b0})
            - $signed({cx2_ff[ABS_W-1], cx2_ff});
      dy_s  = $signed({{2{y_rd_ff[COORD_W-1]}}, y_rd_ff[COORD_W-1:0], 1'b0})
            - $signed({cy2_ff[ABS_W-1], cy2_ff});
      ndx_s = -dx_s;
      ndy_s = -dy_s;
      ax    = dx_s[ABS_W] ? ndx_s[ABS_W-1:0] : dx_s[ABS_W-1:0];
      ay    = dy_s[ABS_W] ? ndy_s[ABS_W-1:0] : dy_s[ABS_W-1:0];
   end

   // shift-add square, digit-by-digit root, radius limit
   always_comb begin
      acc_sum   = acc_ff + (mplier_ff[0] ? {1'b0, mcand_ff} : '0);
      rem_sh    = {rem_ff[REM_W-3:0], src_ff[SRC_W-1 -: 2]};
      trial     = REM_W'({root_ff, 2'b01});
      sq_ge     = (rem_sh >= trial);
      root_next = {root_ff[ROOT_W-2:0], sq_ge};
      lim       = (Q_W'(rad_ff) << 4) + (Q_W'(rad_ff) << 2);
      we_next   = (CNT_W+1)'(we_ff) + 1'b1;
   end

   // status to the controller
   always_comb begin
      stat.i_done    = (i_ff == count_ff);
      stat.t_valid   = t_rd_ff[TIME_W];
      stat.win_more  = (we_next < (CNT_W+1)'(count_ff));
      stat.win_ok    = t_rd_ff[TIME_W] && ((TIME_W+1)'(t_rd_ff[TIME_W-1:0]) <= tend_ff);
      stat.win_multi = (CNT_W'(we_ff) > i_ff);
      stat.g_done    = (k_ff > CNT_W'(we_ff));
      stat.g_both    = x_rd_ff[COORD_W] && y_rd_ff[COORD_W];
      stat.mul_done  = half_ff && (mcount_ff == CYC_W'(ABS_W - 1));
      stat.sqrt_last = (scount_ff == CYC_W'(ROOT_W - 1));
      stat.nv_zero   = (nv_ff == '0);
      stat.sel_done  = (j_ff == nv_ff);
      stat.scan_done = (k2_ff == nv_ff);
      stat.radius_ok = (q10_ff <= lim);
      stat.mark_last = (k_ff[IDX_W-1:0] == we_ff);
   end

   // register next values
   always_comb begin
      logic [CNT_W-1:0]          cnt_eff;
      logic [CNT_W-1:0]          nvm1;
      logic [RANK_T_W-1:0]       tx;
      logic [RANK_T_W+RECIP_W-1:0] prod;
      logic [RANK_T_W-1:0]       tq, mm;
      logic [Q_W-1:0]            p0, p1;
      logic signed [SCR_W-1:0]   vsum;

      cnt_eff   = closed_ff ? '0 : count_ff;
      nvm1      = nv_ff - 1'b1;
      tx        = RANK_T_W'(nvm1);
      prod      = (RANK_T_W+RECIP_W)'(t_ff) * (RANK_T_W+RECIP_W)'(RECIP);
      tq        = RANK_T_W'(q_ff);
      mm        = t_ff - ((tq << 3) + (tq << 1));
      p0        = Q_W'(v0_ff[ROOT_W-1:0]) * Q_W'(4'd10 - m_ff);
      p1        = Q_W'(v1_ff[ROOT_W-1:0]) * Q_W'(m_ff);
      vsum      = v0_ff + v1_ff;

      count_in  = count_ff;   ovf_in    = ovf_ff;     closed_in = closed_ff;
      mst_in    = mst_ff;     rad_in    = rad_ff;
      i_in      = i_ff;       k_in      = k_ff;       nv_in     = nv_ff;
      j_in      = j_ff;       k2_in     = k2_ff;      lt_in     = lt_ff;
      le_in     = le_ff;      we_in     = we_ff;      r0_in     = r0_ff;
      r1_in     = r1_ff;      tend_in   = tend_ff;    cand_in   = cand_ff;
      v0_in     = v0_ff;      v1_in     = v1_ff;      cx2_in    = cx2_ff;
      cy2_in    = cy2_ff;     ay_in     = ay_ff;      mplier_in = mplier_ff;
      mcand_in  = mcand_ff;   acc_in    = acc_ff;     mcount_in = mcount_ff;
      scount_in = scount_ff;  half_in   = half_ff;    src_in    = src_ff;
      rem_in    = rem_ff;     root_in   = root_ff;    t_in      = t_ff;
      q_in      = q_ff;       m_in      = m_ff;       q10_in    = q10_ff;

      rsp_valid_in = read_go;
      rsp_idx_in   = rsp_idx_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_count_in = rsp_count_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      tm_we     = 1'b0;  xy_we = 1'b0;  fl_we = 1'b0;  scr_we = 1'b0;
      fl_wdata  = 1'b0;
      tm_waddr  = cnt_eff[IDX_W-1:0];
      fl_waddr  = cnt_eff[IDX_W-1:0];
      scr_waddr = nv_ff[IDX_W-1:0];
      scr_wdata = SCR_W'(signed'(x_rd_ff[COORD_W-1:0]));
      tm_raddr  = i_ff[IDX_W-1:0];
      xy_raddr  = k_ff[IDX_W-1:0];
      scr_raddr = j_ff[IDX_W-1:0];

      // configuration writes
      if (csr_write) begin
         case (csr_index)
            CSR_MIN_STOP_TIME: mst_in = csr_wdata;
            CSR_STOP_RADIUS:   rad_in = csr_wdata[RAD_W-1:0];
            default: ;
         endcase
      end

      // capture a flag read
      if (read_go) begin
         rsp_idx_in   = req_read_index;
         rsp_hit_in   = (CNT_W'(req_read_index) < count_ff);
         rsp_count_in = count_ff;
         rsp_ovf_in   = ovf_ff;
      end

      // take a point; a closed track starts over first
      if (load_go) begin
         count_in  = cnt_eff;
         ovf_in    = closed_ff ? 1'b0 : ovf_ff;
         closed_in = 1'b0;
         if (cnt_eff < CNT_W'(MAX_POINTS)) begin
            tm_we    = 1'b1;
            xy_we    = 1'b1;
            fl_we    = 1'b1;
            count_in = cnt_eff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
         if (req_final_point) begin
            closed_in = 1'b1;
            i_in      = '0;
            we_in     = '0;
         end
      end

      case (cmd.op)
         DP_OUT_CHK: begin
            if (t_rd_ff[TIME_W]) begin
               tend_in = (TIME_W+1)'(t_rd_ff[TIME_W-1:0]) + (TIME_W+1)'(mst_ff);
               if (CNT_W'(we_ff) < i_ff) we_in = i_ff[IDX_W-1:0];
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         DP_WIN_RD: tm_raddr = we_next[IDX_W-1:0];
         DP_WIN_CHK: begin
            if (stat.win_ok) we_in = we_ff + 1'b1;
         end
         DP_WIN_END: begin
            if (stat.win_multi) begin
               k_in  = i_ff;
               nv_in = '0;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         DP_G_CHK: begin
            case (cmd.pass)
               PASS_X: begin
                  scr_we = x_rd_ff[COORD_W];
                  if (x_rd_ff[COORD_W]) nv_in = nv_ff + 1'b1;
                  k_in = k_ff + 1'b1;
               end
               PASS_Y: begin
                  scr_wdata = SCR_W'(signed'(y_rd_ff[COORD_W-1:0]));
                  scr_we    = y_rd_ff[COORD_W];
                  if (y_rd_ff[COORD_W]) nv_in = nv_ff + 1'b1;
                  k_in = k_ff + 1'b1;
               end
               default: begin
                  if (stat.g_both) begin
                     acc_in    = '0;
                     mcand_in  = (SQ_W-1)'(ax);
                     mplier_in = ax;
                     ay_in     = ay;
                     mcount_in = '0;
                     half_in   = 1'b0;
                  end else begin
                     k_in = k_ff + 1'b1;
                  end
               end
            endcase
         end
         DP_MUL: begin
            acc_in    = acc_sum;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            mcount_in = mcount_ff + 1'b1;
            if (mcount_ff == CYC_W'(ABS_W - 1)) begin
               if (!half_ff) begin
                  mcand_in  = (SQ_W-1)'(ay_ff);
                  mplier_in = ay_ff;
                  mcount_in = '0;
                  half_in   = 1'b1;
               end else begin
                  src_in    = SRC_W'(acc_sum);
                  rem_in    = '0;
                  root_in   = '0;
                  scount_in = '0;
               end
            end
         end
         DP_SQRT: begin
            rem_in    = sq_ge ? (rem_sh - trial) : rem_sh;
            root_in   = root_next;
            src_in    = src_ff << 2;
            scount_in = scount_ff + 1'b1;
            if (stat.sqrt_last) begin
               scr_we    = 1'b1;
               scr_wdata = SCR_W'(root_next);
               nv_in     = nv_ff + 1'b1;
               k_in      = k_ff + 1'b1;
            end
         end
         DP_G_END: begin
            j_in = '0;
            t_in = (tx << 3) + tx;
            if (nv_ff[0]) begin
               r0_in = nv_ff[IDX_W:1];
            end else begin
               r0_in = nv_ff[IDX_W:1] - 1'b1;
            end
            r1_in = nv_ff[IDX_W:1];
            if (stat.nv_zero) i_in = i_ff + 1'b1;
         end
         DP_RANK: q_in = prod[RECIP_SHIFT +: IDX_W];
         DP_RANK2: begin
            m_in  = mm[3:0];
            r0_in = q_ff;
            r1_in = (mm[3:0] == 4'd0) ? q_ff : q_ff + 1'b1;
         end
         DP_SEL_RD: scr_raddr = j_ff[IDX_W-1:0];
         DP_SEL_CAND: begin
            cand_in = scr_rd_ff;
            k2_in   = '0;
            lt_in   = '0;
            le_in   = '0;
         end
         DP_SCAN_RD: scr_raddr = k2_ff[IDX_W-1:0];
         DP_SCAN_CHK: begin
            if (scr_rd_ff < cand_ff) lt_in = lt_ff + 1'b1;
            if (scr_rd_ff <= cand_ff) le_in = le_ff + 1'b1;
            k2_in = k2_ff + 1'b1;
         end
         DP_SCAN_END: begin
            if (lt_ff <= CNT_W'(r0_ff) && CNT_W'(r0_ff) < le_ff) v0_in = cand_ff;
            if (lt_ff <= CNT_W'(r1_ff) && CNT_W'(r1_ff) < le_ff) v1_in = cand_ff;
            j_in = j_ff + 1'b1;
         end
         DP_SEL_END: begin
            case (cmd.pass)
               PASS_X: begin
                  cx2_in = vsum[ABS_W-1:0];
                  k_in   = i_ff;
                  nv_in  = '0;
               end
               PASS_Y: begin
                  cy2_in = vsum[ABS_W-1:0];
                  k_in   = i_ff;
                  nv_in  = '0;
               end
               default: q10_in = p0 + p1;
            endcase
         end
         DP_CMP: begin
            if (stat.radius_ok) begin
               k_in = i_ff;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         DP_MARK: begin
            fl_we    = 1'b1;
            fl_wdata = 1'b1;
            fl_waddr = k_ff[IDX_W-1:0];
            if (stat.mark_last) begin
               i_in = i_ff + 1'b1;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   // memories
   always_ff @(posedge clock) begin
      if (tm_we) time_mem[tm_waddr] <= {req_time_valid, req_time_ms};
      t_rd_ff <= time_mem[tm_raddr];
   end

   always_ff @(posedge clock) begin
      if (xy_we) begin
         x_mem[tm_waddr] <= {req_x_valid, req_coord_x};
         y_mem[tm_waddr] <= {req_y_valid, req_coord_y};
      end
      x_rd_ff <= x_mem[xy_raddr];
      y_rd_ff <= y_mem[xy_raddr];
   end

   always_ff @(posedge clock) begin
      if (fl_we) flag_mem[fl_waddr] <= fl_wdata;
      flag_rd_ff <= flag_mem[req_read_index];
   end

   always_ff @(posedge clock) begin
      if (scr_we) scr_mem[scr_waddr] <= scr_wdata;
      scr_rd_ff <= scr_mem[scr_raddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         closed_ff    <= 1'b0;
         mst_ff       <= MST_RESET;
         rad_ff       <= RAD_RESET;
         rsp_valid_ff <= 1'b0;
         i_ff         <= '0;
         we_ff        <= '0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         closed_ff    <= closed_in;
         mst_ff       <= mst_in;
         rad_ff       <= rad_in;
         rsp_valid_ff <= rsp_valid_in;
         i_ff         <= i_in;
         we_ff        <= we_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      k_ff      <= k_in;       nv_ff     <= nv_in;      j_ff      <= j_in;
      k2_ff     <= k2_in;      lt_ff     <= lt_in;      le_ff     <= le_in;
      r0_ff     <= r0_in;      r1_ff     <= r1_in;      tend_ff   <= tend_in;
      cand_ff   <= cand_in;    v0_ff     <= v0_in;      v1_ff     <= v1_in;
      cx2_ff    <= cx2_in;     cy2_ff    <= cy2_in;     ay_ff     <= ay_in;
      mplier_ff <= mplier_in;  mcand_ff  <= mcand_in;   acc_ff    <= acc_in;
      mcount_ff <= mcount_in;  scount_ff <= scount_in;  half_ff   <= half_in;
      src_ff    <= src_in;     rem_ff    <= rem_in;     root_ff   <= root_in;
      t_ff      <= t_in;       q_ff      <= q_in;       m_ff      <= m_in;
      q10_ff    <= q10_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_count_ff <= rsp_count_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_index = rsp_idx_ff;
   assign rsp_stop_flag   = flag_rd_ff & rsp_hit_ff;
   assign rsp_point_count = rsp_count_ff;
   assign rsp_overflow    = rsp_ovf_ff;

endmodule

/* hw/rtl/trajectory_stop_detector_core.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Word
// req_*     in         start high, busy low   load a point or read a flag
// rsp_*     out        rsp_valid, one cycle   flag of one point
// csr_*     in         csr_valid & csr_ready  register index and value
//
// Loads and reads are taken while busy is low; a read answers next cycle.
// A load with final_point runs the window evaluation, busy meanwhile; its
// length is set by the serial scratch memory scan in each of the three
// selections and the bit-serial square and root unit for each distance.
// Sync reset clears count and overflow, hiding flags; CSRs get defaults.
// The receiver cannot stall; csr_ready is always high.

`include "trajectory_stop_detector_core_macros.svh"

module trajectory_stop_detector_core
   import tsd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_operation,
   input  logic [TIME_W-1:0]         req_time_ms,
   input  logic                      req_time_valid,
   input  logic signed [COORD_W-1:0] req_coord_x,
   input  logic                      req_x_valid,
   input  logic signed [COORD_W-1:0] req_coord_y,
   input  logic                      req_y_valid,
   input  logic                      req_final_point,
   input  logic [IDX_W-1:0]          req_read_index,
   output logic                      rsp_valid,
   output logic [IDX_W-1:0]          rsp_point_index,
   output logic                      rsp_stop_flag,
   output logic [CNT_W-1:0]          rsp_point_count,
   output logic                      rsp_overflow,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic        req_accept, load_go, read_go, eval_go;

   // decode the accepted word
   assign req_accept = start & ~busy;
   assign load_go    = req_accept & (req_operation == OP_LOAD);
   assign read_go    = req_accept & (req_operation == OP_READ);
   assign eval_go    = load_go & req_final_point;
   assign csr_ready  = 1'b1;

   tsd_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .eval_go (eval_go),
      .stat    (stat),
      .cmd     (cmd),
      .busy    (busy)
   );

   tsd_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .load_go         (load_go),
      .read_go         (read_go),
      .req_time_ms     (req_time_ms),
      .req_time_valid  (req_time_valid),
      .req_coord_x     (req_coord_x),
      .req_x_valid     (req_x_valid),
      .req_coord_y     (req_coord_y),
      .req_y_valid     (req_y_valid),
      .req_final_point (req_final_point),
      .req_read_index  (req_read_index),
      .csr_write       (csr_valid & csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_point_index (rsp_point_index),
      .rsp_stop_flag   (rsp_stop_flag),
      .rsp_point_count (rsp_point_count),
      .rsp_overflow    (rsp_overflow)
   );

   `TSD_ASSERT_NEXT(a_read_gives_rsp, clock, reset, read_go, rsp_valid)
   `TSD_ASSERT_SAME(a_rsp_after_read, clock, reset, rsp_valid, $past(read_go))
   `TSD_ASSERT_SAME(a_busy_from_final, clock, reset, $rose(busy), $past(eval_go))
   `TSD_ASSERT_SAME(a_count_range, clock, reset, rsp_valid, rsp_point_count <= CNT_W'(MAX_POINTS))

endmodule

/* dv/trajectory_stop_detector_core_tb.sv */
`timescale 1ns / 1ps

module trajectory_stop_detector_core_tb;
   import tsd_pkg::*;

   localparam int CYCLE_LIMIT = 12_000_000;
   localparam int ITEM_TARGET = 1850;
   localparam int CALM_ITEMS  = 200;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = CSR_IDX_W'(9);

   // One request word and one flag word
   typedef struct {
      req_op_type               op;
      logic [TIME_W-1:0]        tm;
      logic                     tv;
      logic signed [COORD_W-1:0] x;
      logic                     xv;
      logic signed [COORD_W-1:0] y;
      logic                     yv;
      logic                     fin;
      logic [IDX_W-1:0]         ridx;
   } point_word_type;

   typedef struct {
      logic [IDX_W-1:0] idx;
      logic             flag;
      logic [CNT_W-1:0] cnt;
      logic             ovf;
   } flag_word_type;

   typedef struct {
      point_word_type w;
      bit             typed;
      flag_word_type  e;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_operation = 1'b0;
   logic [TIME_W-1:0] req_time_ms = '0;
   logic req_time_valid = 1'b0;
   logic signed [COORD_W-1:0] req_coord_x = '0;
   logic req_x_valid = 1'b0;
   logic signed [COORD_W-1:0] req_coord_y = '0;
   logic req_y_valid = 1'b0;
   logic req_final_point = 1'b0;
   logic [IDX_W-1:0] req_read_index = '0;
   logic rsp_valid;
   logic [IDX_W-1:0] rsp_point_index;
   logic rsp_stop_flag;
   logic [CNT_W-1:0] rsp_point_count;
   logic rsp_overflow;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   trajectory_stop_detector_core uut (.*);

   // Shadow of the track held by the core
   logic [TIME_W-1:0]  trk_time [MAX_POINTS];
   bit                 trk_tv   [MAX_POINTS];
   logic signed [COORD_W-1:0] trk_x [MAX_POINTS];
   bit                 trk_xv   [MAX_POINTS];
   logic signed [COORD_W-1:0] trk_y [MAX_POINTS];
   bit                 trk_yv   [MAX_POINTS];
   bit                 trk_flag [MAX_POINTS];
   int                 trk_count;
   bit                 trk_overflow;
   bit                 trk_closed;
   longint unsigned    win_len_ms;
   longint unsigned    radius;

   flag_word_type pending_flags[$];
   int errors;
   int items;
   int reads_seen;
   int stops_seen;
   int cycles;

   initial begin
      forever #5 clock = ~clock;
   end

   // Exact floor of the euclidean length of (ax, ay)
   function automatic longint unsigned floor_hypot(logic [ABS_W-1:0] ax, logic [ABS_W-1:0] ay);
      logic [69:0] sq;
      logic [69:0] c;
      logic [34:0] r;
      sq = 70'(ax) * 70'(ax) + 70'(ay) * 70'(ay);
      r = '0;
      for (int b = 34; b >= 0; b--) begin
         c = 70'(r | (35'd1 << b));
         if (c * c <= sq) r = r | (35'd1 << b);
      end
      return longint'(r);
   endfunction

   // Median centre, 90th percentile distance, mark window if it fits
   function automatic void judge_window(int s, int e);
      longint xs[$];
      longint ys[$];
      longint unsigned ds[$];
      longint cx2, cy2, dx, dy;
      longint unsigned q10;
      int n, t, i, m;
      for (int k = s; k <= e; k++) begin
         if (trk_xv[k]) xs = {xs, longint'(trk_x[k])};
         if (trk_yv[k]) ys = {ys, longint'(trk_y[k])};
      end
      if (xs.size() == 0 || ys.size() == 0) return;
      xs.sort();
      ys.sort();
      n = xs.size();
      cx2 = (n % 2) ? 2 * xs[n/2] : xs[n/2-1] + xs[n/2];
      n = ys.size();
      cy2 = (n % 2) ? 2 * ys[n/2] : ys[n/2-1] + ys[n/2];
      for (int k = s; k <= e; k++) begin
         if (trk_xv[k] && trk_yv[k]) begin
            dx = 2 * longint'(trk_x[k]) - cx2;
            dy = 2 * longint'(trk_y[k]) - cy2;
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            ds = {ds, floor_hypot(ABS_W'(dx), ABS_W'(dy))};
         end
      end
      if (ds.size() == 0) return;
      ds.sort();
      n = ds.size();
      if (n == 1) begin
         q10 = 10 * ds[0];
      end else begin
         t = 9 * (n - 1);
         i = t / 10;
         m = t % 10;
         q10 = longint'(10 - m) * ds[i] + longint'(m) * ds[i+1];
      end
      if (q10 <= 20 * radius) begin
         stops_seen++;
         for (int k = s; k <= e; k++) trk_flag[k] = 1'b1;
      end
   endfunction

   // Forward window scan over the closed track
   function automatic void scan_track();
      int wend;
      longint unsigned t_end;
      wend = 0;
      for (int i = 0; i < trk_count; i++) begin
         if (!trk_tv[i]) continue;
         t_end = longint'(trk_time[i]) + win_len_ms;
         if (wend < i) wend = i;
         while (wend + 1 < trk_count && trk_tv[wend+1] && longint'(trk_time[wend+1]) <= t_end)
            wend++;
         if (wend - i + 1 >= 2) judge_window(i, wend);
      end
   endfunction

   // Apply one accepted word to the shadow; return the flag word of a read
   function automatic flag_word_type track_update(point_word_type w);
      flag_word_type r;
      r = '{default: '0};
      if (w.op == OP_READ) begin
         r.idx = w.ridx;
         r.flag = (int'(w.ridx) < trk_count) ? trk_flag[w.ridx] : 1'b0;
         r.cnt = CNT_W'(trk_count);
         r.ovf = trk_overflow;
         return r;
      end
      if (trk_closed) begin
         trk_count = 0;
         trk_overflow = 0;
         trk_closed = 0;
         foreach (trk_flag[k]) trk_flag[k] = 1'b0;
      end
      if (trk_count < MAX_POINTS) begin
         trk_time[trk_count] = w.tm;
         trk_tv[trk_count] = w.tv;
         trk_x[trk_count] = w.x;
         trk_xv[trk_count] = w.xv;
         trk_y[trk_count] = w.y;
         trk_yv[trk_count] = w.yv;
         trk_flag[trk_count] = 1'b0;
         trk_count++;
      end else begin
         trk_overflow = 1;
      end
      if (w.fin) begin
         scan_track();
         trk_closed = 1;
      end
      return r;
   endfunction

   // Present one word, hold until accepted, then queue the flag word of a read
   task automatic send_word(point_word_type w, bit typed, flag_word_type e);
      flag_word_type got;
      start <= 1'b1;
      req_operation <= w.op;
      req_time_ms <= w.tm;
      req_time_valid <= w.tv;
      req_coord_x <= w.x;
      req_x_valid <= w.xv;
      req_coord_y <= w.y;
      req_y_valid <= w.yv;
      req_final_point <= w.fin;
      req_read_index <= w.ridx;
      do @(posedge clock); while (busy);
      got = track_update(w);
      if (typed) got = e;
      if (w.op == OP_READ) pending_flags = {pending_flags, got};
      items++;
      // random idle burst, none near the end
      if (items < ITEM_TARGET - CALM_ITEMS && $urandom_range(0, 4) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   task automatic send(point_word_type w);
      flag_word_type none;
      none = '{default: '0};
      send_word(w, 1'b0, none);
   endtask

   // Drain all flag words and let any evaluation finish
   task automatic settle();
      start <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending_flags.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write one register, then leave the channel idle
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_MIN_STOP_TIME) win_len_ms = longint'(val);
      else if (idx == CSR_STOP_RADIUS) radius = longint'(val[RAD_W-1:0]);
      @(posedge clock);
   endtask

   function automatic point_word_type load_word(logic [TIME_W-1:0] tm, logic tv,
         logic signed [COORD_W-1:0] x, logic xv, logic signed [COORD_W-1:0] y,
         logic yv, logic fin);
      point_word_type w;
      w = '{op: OP_LOAD, tm: tm, tv: tv, x: x, xv: xv, y: y, yv: yv, fin: fin,
            ridx: IDX_W'($urandom)};
      return w;
   endfunction

   function automatic point_word_type read_word(logic [IDX_W-1:0] idx);
      point_word_type w;
      w = '{op: OP_READ, tm: TIME_W'({$urandom, $urandom}), tv: 1'($urandom),
            x: $urandom, xv: 1'($urandom), y: $urandom, yv: 1'($urandom),
            fin: 1'($urandom), ridx: idx};
      return w;
   endfunction

   function automatic stim_row_type row(point_word_type w, bit typed, int idx, bit flag,
         int cnt, bit ovf);
      stim_row_type r;
      r.w = w;
      r.typed = typed;
      r.e = '{idx: IDX_W'(idx), flag: flag, cnt: CNT_W'(cnt), ovf: ovf};
      return r;
   endfunction

   // One random track: clustered points, then reads of its flags
   task automatic random_track();
      int len;
      longint unsigned t, step;
      longint cx, cy, spread;
      bit unsorted;
      len = $urandom_range(2, (win_len_ms >= 64'h8000_0000) ? 5 : 10);
      unsorted = ($urandom_range(0, 9) == 0);
      t = ($urandom_range(0, 15) == 0) ? 64'hFF_FFFF_0000 + $urandom_range(0, 4096)
                                        : longint'($urandom);
      step = win_len_ms / 3;
      cx = longint'($signed($urandom));
      cy = longint'($signed($urandom));
      if (radius == 0) spread = $urandom_range(0, 1);
      else begin
         spread = radius >> $urandom_range(0, 3);
         if (spread > 64'h1000_0000) spread = 64'h1000_0000;
         if ($urandom_range(0, 3) == 0) spread = spread * 4;
      end
      for (int k = 0; k < len; k++) begin
         point_word_type w;
         logic signed [COORD_W-1:0] x, y;
         if ($urandom_range(0, 19) == 0) begin
            x = $urandom;
            y = $urandom;
         end else begin
            x = COORD_W'(cx + longint'($urandom_range(0, 2 * spread)) - spread);
            y = COORD_W'(cy + longint'($urandom_range(0, 2 * spread)) - spread);
         end
         w = load_word(unsorted ? TIME_W'({$urandom, $urandom}) : TIME_W'(t),
                       $urandom_range(0, 9) != 0, x, $urandom_range(0, 9) != 0,
                       y, $urandom_range(0, 9) != 0, k == len - 1);
         send(w);
         if ($urandom_range(0, 7) == 0) send(read_word(IDX_W'($urandom_range(0, len))));
         if (win_len_ms < 4) t = t + $urandom_range(0, 1);
         else t = t + step * $urandom_range(0, 6) / 4;
         if (t > 64'hFF_FFFF_FFFF) t = 64'hFF_FFFF_FFFF;
      end
      // read back the track, plus a stray index now and then
      for (int k = 0; k < len; k++)
         if ($urandom_range(0, 2) != 0) send(read_word(IDX_W'(k)));
      if ($urandom_range(0, 3) == 0) send(read_word(IDX_W'($urandom)));
   endtask

   // Check each flag word against the oldest expectation
   always @(posedge clock) begin
      flag_word_type e;
      if (!reset && rsp_valid) begin
         reads_seen++;
         if (pending_flags.size() == 0) begin
            $error("flag word with nothing expected, index %0d", rsp_point_index);
            errors++;
         end else begin
            e = pending_flags.pop_front();
            if (rsp_point_index !== e.idx) begin
               $error("point_index expected %0d got %0d", e.idx, rsp_point_index);
               errors++;
            end
            if (rsp_stop_flag !== e.flag) begin
               $error("stop_flag expected %0d got %0d", e.flag, rsp_stop_flag);
               errors++;
            end
            if (rsp_point_count !== e.cnt) begin
               $error("point_count expected %0d got %0d", e.cnt, rsp_point_count);
               errors++;
            end
            if (rsp_overflow !== e.ovf) begin
               $error("overflow expected %0d got %0d", e.ovf, rsp_overflow);
               errors++;
            end
         end
      end
   end

   // Watchdog
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("trajectory_stop_detector_core_tb NOT OK");
            $finish;
         end
      end
   end

   initial begin
      stim_row_type rows[$];
      logic [MST_W-1:0] mst_set[4];
      logic [RAD_W-1:0] rad_set[4];
      errors = 0;
      items = 0;
      reads_seen = 0;
      stops_seen = 0;
      trk_count = 0;
      trk_overflow = 0;
      trk_closed = 0;
      win_len_ms = MST_RESET;
      radius = RAD_RESET;
      foreach (trk_flag[k]) trk_flag[k] = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty reads, field extremes, invalid fields, track restart
      rows = {rows, row(read_word(0), 1, 0, 0, 0, 0)};
      rows = {rows, row(read_word(1023), 1, 1023, 0, 0, 0)};
      rows = {rows, row(load_word(0, 1, 32'sh7FFF_FFFF, 1, -32'sh8000_0000, 1, 0), 0, 0, 0, 0, 0)};
      rows = {rows, row(load_word('1, 1, -32'sh8000_0000, 1, 32'sh7FFF_FFFF, 1, 0), 0, 0, 0, 0, 0)};
      rows = {rows, row(load_word(40'h55_5555_5555, 0, 0, 0, 0, 1, 0), 0, 0, 0, 0, 0)};
      rows = {rows, row(load_word('1, 1, 0, 0, 32'sh5555_5555, 1, 0), 0, 0, 0, 0, 0)};
      rows = {rows, row(load_word('1, 1, 0, 1, 0, 0, 0), 0, 0, 0, 0, 0)};
      rows = {rows, row(load_word('1, 1, -1, 1, -1, 1, 1), 0, 0, 0, 0, 0)};
      for (int k = 0; k < 6; k++) rows = {rows, row(read_word(IDX_W'(k)), 0, 0, 0, 0, 0)};
      rows = {rows, row(read_word(6), 1, 6, 0, 6, 0)};
      rows = {rows, row(load_word(100, 1, 256, 1, 256, 1, 0), 0, 0, 0, 0, 0)};
      rows = {rows, row(read_word(0), 1, 0, 0, 1, 0)};
      rows = {rows, row(load_word(200, 1, 300, 1, 200, 1, 0), 0, 0, 0, 0, 0)};
      rows = {rows, row(load_word(150, 1, 280, 1, 260, 1, 0), 0, 0, 0, 0, 0)};
      rows = {rows, row(load_word(300, 1, 250, 1, 240, 1, 1), 0, 0, 0, 0, 0)};
      for (int k = 0; k < 4; k++) rows = {rows, row(read_word(IDX_W'(k)), 0, 0, 0, 0, 0)};
      foreach (rows[r]) send_word(rows[r].w, rows[r].typed, rows[r].e);
      settle();

      // Random tracks under several register settings, extremes included
      mst_set = '{32'd0, 32'hFFFF_FFFF, 32'd1000, 32'd50000};
      rad_set = '{31'd0, 31'h7FFF_FFFF, 31'd256, 31'd3000};
      for (int p = 0; p < 5; p++) begin
         if (p > 0) begin
            write_reg(CSR_MIN_STOP_TIME, mst_set[p-1]);
            write_reg(CSR_STOP_RADIUS, CSR_DATA_W'(rad_set[p-1]));
            if (p == 1) write_reg(CSR_UNUSED, $urandom);
         end
         // capacity overflow once: mostly untimed points, a timed cluster at the end
         if (p == 3) begin
            for (int k = 0; k < MAX_POINTS + 6; k++)
               send(load_word(TIME_W'(k), k >= MAX_POINTS - 4,
                              32'sd1000 + $urandom_range(0, 200), 1,
                              -32'sd500 + $urandom_range(0, 200), 1,
                              k == MAX_POINTS + 5));
            send(read_word(1023));
            send(read_word(1022));
            send(read_word(IDX_W'($urandom)));
            send(load_word(5, 1, 0, 1, 0, 1, 0));
            send(read_word(0));
         end
         while (items < 320 + (p + 1) * (ITEM_TARGET - 1400) / 5 + (p >= 3 ? 1030 : 0))
            random_track();
         settle();
      end

      settle();
      repeat (20) @(posedge clock);
      $display("%0d words sent, %0d flag words checked, %0d stop windows over 5 settings",
               items, reads_seen, stops_seen);
      $display("covered field extremes, invalid fields, capacity overflow, restart of tracks");
      if (errors == 0) begin
         $display("trajectory_stop_detector_core_tb OK");
      end else begin
         $display("trajectory_stop_detector_core_tb NOT OK");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/tsd_pkg.sv
hw/rtl/tsd_ctrl.sv
hw/rtl/tsd_datapath.sv
hw/rtl/trajectory_stop_detector_core.sv
dv/trajectory_stop_detector_core_tb.sv
